[rtl/core/mfc_pkg.sv]
// Package with the constants and types of the meter frame checker.
package mfc_pkg;

  localparam int unsigned AddressBytes = 6;
  localparam int unsigned AddrW        = 8 * AddressBytes;
  localparam int unsigned MeterAddrW   = 48;
  localparam int unsigned PosW         = 4;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [PosW-1:0] PosMax       = 4'd15;
  localparam logic [PosW-1:0] MinFrameLen  = 4'd7;
  localparam logic [PosW-1:0] FramePos     = PosW'(AddressBytes + 1);
  localparam logic [PosW-1:0] ControlPos   = PosW'(AddressBytes + 2);
  localparam logic [7:0]      StartCode    = 8'h68;
  localparam logic [7:0]      StopCode     = 8'h16;
  localparam int unsigned     DirSlaveBit  = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMeterAddress  = 2'd0,
    CfgAddrCheckEn   = 2'd1
  } cfg_index_e;

  typedef enum logic [2:0] {
    StatOk        = 3'd0,
    StatShort     = 3'd1,
    StatFraming   = 3'd2,
    StatChecksum  = 3'd3,
    StatDirection = 3'd4,
    StatAddress   = 3'd5
  } status_e;

endpackage

[rtl/core/meter_frame_checker_top.sv]
// Byte-serial validity checker for meter frames with one status per frame.
//
// Frame bytes enter on the input channel (in_valid_i / in_ready_o), one byte
// per request, with last_byte_i set on the final byte of each frame. For every
// final byte the block returns one result request on the output channel
// (out_valid_o / out_ready_i) carrying the status code and the control byte.
// Bytes that are not final produce no result.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes the meter
// address (index 0) and the address check enable (index 1); it is always
// ready and is meant to be used while no frame is in flight.
// A byte is held in an input register and then folded into the running frame
// state by a single stage of logic. The result is registered from the input
// register once the final byte advances, and one byte is taken in every
// cycle as long as the output register is free or being drained.
// When the receiver stalls, a pending final byte waits in the input register
// and further bytes are refused; bytes that are not final keep flowing.
// Reset clears the frame state and the output, sets the meter address to zero
// and enables the address check.
module meter_frame_checker_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      frame_byte_i,
  input  logic                            last_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      status_o,
  output logic [7:0]                      control_code_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mfc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mfc_pkg::MeterAddrW-1:0]  cfg_data_i
);
  import mfc_pkg::*;

  logic                  in_valid_q;
  logic [7:0]            byte_q;
  logic                  last_q;
  logic                  adv;

  logic [MeterAddrW-1:0] meter_addr_q;
  logic                  addr_chk_en_q;

  logic [PosW-1:0]       pos_q, pos_d;
  logic [7:0]            lsum_q, lsum_d;
  logic [7:0]            older_q, older_d;
  logic [7:0]            newer_q, newer_d;
  logic [1:0]            start_ok_q, start_ok_d;
  logic [7:0]            ctrl_q, ctrl_d;
  logic [AddrW-1:0]      addr_q, addr_d;

  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [7:0]            ctrl_out_q;
  logic [AddrW-1:0]      meter_cmp;

  assign cfg_ready_o = 1'b1;
  assign adv         = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meter_addr_q  <= '0;
      addr_chk_en_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgMeterAddress: meter_addr_q  <= cfg_data_i;
        CfgAddrCheckEn:  addr_chk_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= frame_byte_i;
      last_q <= last_byte_i;
    end
  end

  // Extra address bytes beyond the configured width compare with zero.
  always_comb begin
    meter_cmp = '0;
    for (int i = 0; i < AddrW && i < MeterAddrW; i++) begin
      meter_cmp[i] = meter_addr_q[i];
    end
  end

  always_comb begin
    logic [7:0]      sum_chk;
    logic [AddrW-1:0] addr_n;
    logic [1:0]      ok_n;
    logic [7:0]      ctrl_n;
    sum_chk = lsum_q + older_q;
    ok_n    = start_ok_q;
    ctrl_n  = ctrl_q;
    addr_n  = addr_q;
    if (pos_q == '0 && byte_q == StartCode) begin
      ok_n[0] = 1'b1;
    end
    if (pos_q == FramePos && byte_q == StartCode) begin
      ok_n[1] = 1'b1;
    end
    if (pos_q == ControlPos) begin
      ctrl_n = byte_q;
    end
    for (int i = 0; i < AddressBytes; i++) begin
      if (pos_q == PosW'(i + 1)) begin
        addr_n[8*i +: 8] = byte_q;
      end
    end

    if (pos_q < MinFrameLen - 4'd1) begin
      status_d = StatShort;
    end else if (ok_n != 2'b11 || byte_q != StopCode) begin
      status_d = StatFraming;
    end else if (sum_chk != newer_q) begin
      status_d = StatChecksum;
    end else if (ctrl_n[DirSlaveBit]) begin
      status_d = StatDirection;
    end else if (addr_chk_en_q && addr_n != meter_cmp) begin
      status_d = StatAddress;
    end else begin
      status_d = StatOk;
    end

    if (last_q) begin
      pos_d      = '0;
      lsum_d     = '0;
      older_d    = '0;
      newer_d    = '0;
      start_ok_d = '0;
      ctrl_d     = '0;
      addr_d     = '0;
    end else begin
      pos_d      = (pos_q == PosMax) ? PosMax : pos_q + 4'd1;
      lsum_d     = sum_chk;
      older_d    = newer_q;
      newer_d    = byte_q;
      start_ok_d = ok_n;
      ctrl_d     = ctrl_n;
      addr_d     = addr_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      lsum_q     <= '0;
      older_q    <= '0;
      newer_q    <= '0;
      start_ok_q <= '0;
      ctrl_q     <= '0;
      addr_q     <= '0;
    end else if (adv) begin
      pos_q      <= pos_d;
      lsum_q     <= lsum_d;
      older_q    <= older_d;
      newer_q    <= newer_d;
      start_ok_q <= start_ok_d;
      ctrl_q     <= ctrl_d;
      addr_q     <= addr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      status_q   <= status_d;
      ctrl_out_q <= (pos_q > ControlPos) ? ctrl_q :
                    (pos_q == ControlPos) ? byte_q : 8'h00;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign control_code_o = ctrl_out_q;

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q && last_q))
    else $error("result appeared without a final byte");

  a_final_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && last_q && out_valid_q && !out_ready_i) |=> in_valid_q && last_q)
    else $error("final byte dropped while result stalled");

  a_frame_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_q) |=> (pos_q == '0 && lsum_q == '0 && start_ok_q == '0))
    else $error("frame state not cleared after final byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(adv && last_q))
    else $error("pending result overwritten");

endmodule
